@@ hdl/point_in_polygon_winding_defines.svh @@
// Assertion helpers shared by the point-in-polygon block.
`ifndef POINT_IN_POLYGON_WINDING_DEFINES_SVH
`define POINT_IN_POLYGON_WINDING_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PIPW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PIPW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pipw_pkg.sv @@
package pipw_pkg;

    localparam int COORD_WIDTH_DEF  = 16;
    localparam int MAX_VERTICES_DEF = 256;
    localparam int QUEUE_DEPTH      = 4;

    // quadrant step between the endpoints of an edge, wrapping around the quadrants
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_CCW  = 2'd1,
        STEP_DIAG = 2'd2,
        STEP_CW   = 2'd3
    } step_t;

    typedef struct packed {
        logic  first;      // first vertex: restart the sum, no incoming edge
        logic  last;       // closing vertex: add closing edge and report
        step_t step_prev;  // edge previous vertex -> this vertex
        step_t step_close; // edge this vertex -> first vertex
    } edge_ctrl_t;

    // quadrant from the signs of (p - q)
    function automatic logic [1:0] quadrant(input logic neg_x, input logic neg_y);
        logic [1:0] q;
        if (neg_x)
        begin
            q = neg_y ? 2'd2 : 2'd1;
        end
        else
        begin
            q = neg_y ? 2'd3 : 2'd0;
        end
        return q;
    endfunction

    // winding contribution of one edge
    function automatic logic signed [2:0] step_delta(input step_t s, input logic cross_neg);
        logic signed [2:0] d;
        unique case (s)
            STEP_NONE: d = 3'sd0;
            STEP_CCW:  d = 3'sd1;
            STEP_CW:   d = -3'sd1;
            STEP_DIAG: d = cross_neg ? -3'sd2 : 3'sd2;
            default:   d = 3'sd0;
        endcase
        return d;
    endfunction

endpackage

@@ hdl/pipw_front.sv @@
module pipw_front #(
    parameter int COORD_WIDTH = pipw_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    input  logic                          is_last,
    output logic signed [COORD_WIDTH:0]   dx,
    output logic signed [COORD_WIDTH:0]   dy,
    output logic signed [COORD_WIDTH:0]   pdx,
    output logic signed [COORD_WIDTH:0]   pdy,
    output logic signed [COORD_WIDTH:0]   fdx,
    output logic signed [COORD_WIDTH:0]   fdy,
    output pipw_pkg::edge_ctrl_t          ctrl
);
    import pipw_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    logic                   mid_reg, mid_next;
    logic [COORD_WIDTH-1:0] qx_reg, qy_reg;
    logic [DW-1:0]          pdx_reg, pdy_reg, fdx_reg, fdy_reg;
    logic [1:0]             pq_reg, fq_reg;

    logic [COORD_WIDTH-1:0] qx_use, qy_use;
    logic [1:0]             quad, fq_use;

    // query comes straight from the request on the first vertex
    assign qx_use = mid_reg ? qx_reg : query_x;
    assign qy_use = mid_reg ? qy_reg : query_y;

    assign dx = signed'({vertex_x[COORD_WIDTH-1], vertex_x} - {qx_use[COORD_WIDTH-1], qx_use});
    assign dy = signed'({vertex_y[COORD_WIDTH-1], vertex_y} - {qy_use[COORD_WIDTH-1], qy_use});

    assign quad   = quadrant(dx[DW-1], dy[DW-1]);
    assign fq_use = mid_reg ? fq_reg : quad;

    assign pdx = signed'(pdx_reg);
    assign pdy = signed'(pdy_reg);
    assign fdx = mid_reg ? signed'(fdx_reg) : dx;
    assign fdy = mid_reg ? signed'(fdy_reg) : dy;

    always_comb
    begin
        ctrl.first      = !mid_reg;
        ctrl.last       = is_last;
        ctrl.step_prev  = mid_reg ? step_t'(quad - pq_reg) : STEP_NONE;
        ctrl.step_close = step_t'(fq_use - quad);
    end

    assign mid_next = !is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= 1'b0;
        end
        else if (accept)
        begin
            mid_reg <= mid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!mid_reg)
            begin
                qx_reg  <= query_x;
                qy_reg  <= query_y;
                fdx_reg <= dx;
                fdy_reg <= dy;
                fq_reg  <= quad;
            end
            pdx_reg <= dx;
            pdy_reg <= dy;
            pq_reg  <= quad;
        end
    end

endmodule

@@ hdl/pipw_queue.sv @@
module pipw_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);
    import pipw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? PTR_W'((32'(wr_reg) + 1) % QUEUE_DEPTH) : wr_reg;
        rd_next  = pop  ? PTR_W'((32'(rd_reg) + 1) % QUEUE_DEPTH) : rd_reg;
        cnt_next = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/pipw_back.sv @@
module pipw_back #(
    parameter int COORD_WIDTH  = pipw_pkg::COORD_WIDTH_DEF,
    parameter int MAX_VERTICES = pipw_pkg::MAX_VERTICES_DEF,
    parameter int ACC_W        = $clog2(MAX_VERTICES) + 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop,
    input  logic signed [COORD_WIDTH:0] dx,
    input  logic signed [COORD_WIDTH:0] dy,
    input  logic signed [COORD_WIDTH:0] pdx,
    input  logic signed [COORD_WIDTH:0] pdy,
    input  logic signed [COORD_WIDTH:0] fdx,
    input  logic signed [COORD_WIDTH:0] fdy,
    input  pipw_pkg::edge_ctrl_t        ctrl,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        inside_res,
    output logic signed [ACC_W-1:0]     quarter_turns
);
    import pipw_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam logic signed [ACC_W:0] AccMax = (ACC_W+1)'(2 * MAX_VERTICES);
    localparam logic signed [ACC_W:0] AccMin = -AccMax;
    localparam logic signed [ACC_W-1:0] Two  = ACC_W'(2);

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [2:0]       d
    );
        logic signed [ACC_W:0] s;
        s = signed'({a[ACC_W-1], a}) + signed'({{(ACC_W-2){d[2]}}, d});
        if (s > AccMax)
        begin
            s = AccMax;
        end
        else if (s < AccMin)
        begin
            s = AccMin;
        end
        return s[ACC_W-1:0];
    endfunction

    // product stage
    logic                 b1_valid_reg, b1_valid_next;
    edge_ctrl_t           b1_ctrl_reg;
    logic signed [PW-1:0] p1a_reg, p1b_reg, p2a_reg, p2b_reg;
    logic signed [PW-1:0] p1a_next, p1b_next, p2a_next, p2b_next;

    // accumulate stage
    logic                    adv;
    logic signed [ACC_W-1:0] acc_reg, acc_next, base, sum1, sum2;
    logic signed [PW:0]      cross1, cross2;
    logic signed [2:0]       d1, d2;
    logic                    out_valid_reg, out_valid_next;
    logic                    inside_reg;
    logic signed [ACC_W-1:0] qt_reg;

    assign adv = !(out_valid_reg && out_stall);
    assign pop = adv && pop_valid;

    always_comb
    begin
        p1a_next      = dy * pdx;
        p1b_next      = dx * pdy;
        p2a_next      = fdy * dx;
        p2b_next      = fdx * dy;
        b1_valid_next = pop_valid;
    end

    always_comb
    begin
        cross1 = signed'({p1a_reg[PW-1], p1a_reg}) - signed'({p1b_reg[PW-1], p1b_reg});
        cross2 = signed'({p2a_reg[PW-1], p2a_reg}) - signed'({p2b_reg[PW-1], p2b_reg});
        d1     = step_delta(b1_ctrl_reg.step_prev, cross1[PW]);
        d2     = b1_ctrl_reg.last ? step_delta(b1_ctrl_reg.step_close, cross2[PW]) : 3'sd0;
        base   = b1_ctrl_reg.first ? '0 : acc_reg;
        sum1   = sat_add(base, d1);
        sum2   = sat_add(sum1, d2);
        acc_next       = b1_ctrl_reg.last ? '0 : sum2;
        out_valid_next = b1_valid_reg && b1_ctrl_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
            if (b1_valid_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_ctrl_reg <= ctrl;
            p1a_reg     <= p1a_next;
            p1b_reg     <= p1b_next;
            p2a_reg     <= p2a_next;
            p2b_reg     <= p2b_next;
            if (out_valid_next)
            begin
                inside_reg <= (sum2 >= Two) || (sum2 <= -Two);
                qt_reg     <= sum2;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign inside_res    = inside_reg;
    assign quarter_turns = qt_reg;

endmodule

@@ hdl/point_in_polygon_winding.sv @@
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | vertex_x, vertex_y, query_x, query_y, is_last
// out     | output    | out_valid/out_stall | inside_res, quarter_turns
//
// One vertex request per cycle while in_stall is low; the front end, a four-entry
// queue and a two-stage back end (cross products, then accumulate) register a
// result once the closing vertex has passed through them.
// Reset (rst_n low, asynchronous) empties the queue and pipeline and waits
// for the first vertex of a new polygon.
// in_stall is high only while the queue is full; out_stall, while out_valid is high,
// holds the result register and freezes the back end, which backs up into the queue.
`include "point_in_polygon_winding_defines.svh"

module point_in_polygon_winding #(
    parameter int COORD_WIDTH  = pipw_pkg::COORD_WIDTH_DEF,
    parameter int MAX_VERTICES = pipw_pkg::MAX_VERTICES_DEF,
    parameter int ACC_W        = $clog2(MAX_VERTICES) + 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    input  logic                          is_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          inside_res,
    output logic signed [ACC_W-1:0]       quarter_turns
);
    import pipw_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    // queue entry: edge control plus six query-relative coordinates
    localparam int QW = $bits(edge_ctrl_t) + 6 * DW;
    localparam logic signed [ACC_W-1:0] AccLimit = ACC_W'(2 * MAX_VERTICES);
    localparam logic signed [ACC_W-1:0] Two      = ACC_W'(2);

    logic                 accept;
    logic signed [DW-1:0] f_dx, f_dy, f_pdx, f_pdy, f_fdx, f_fdy;
    edge_ctrl_t           f_ctrl;

    logic                 q_full, q_pop, q_pop_valid;
    logic [QW-1:0]        q_push_data, q_pop_data;

    logic signed [DW-1:0] b_dx, b_dy, b_pdx, b_pdy, b_fdx, b_fdy;
    edge_ctrl_t           b_ctrl;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // front: latch query, classify quadrants, form both edges of the vertex
    pipw_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .vertex_x (vertex_x),
        .vertex_y (vertex_y),
        .query_x  (query_x),
        .query_y  (query_y),
        .is_last  (is_last),
        .dx       (f_dx),
        .dy       (f_dy),
        .pdx      (f_pdx),
        .pdy      (f_pdy),
        .fdx      (f_fdx),
        .fdy      (f_fdy),
        .ctrl     (f_ctrl)
    );

    assign q_push_data = {f_ctrl, f_dx, f_dy, f_pdx, f_pdy, f_fdx, f_fdy};

    pipw_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_pop_valid),
        .pop_data  (q_pop_data)
    );

    assign {b_ctrl, b_dx, b_dy, b_pdx, b_pdy, b_fdx, b_fdy} = q_pop_data;

    // back: cross-product sign on diagonal steps, saturating winding sum
    pipw_back #(
        .COORD_WIDTH  (COORD_WIDTH),
        .MAX_VERTICES (MAX_VERTICES),
        .ACC_W        (ACC_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (q_pop_valid),
        .pop           (q_pop),
        .dx            (b_dx),
        .dy            (b_dy),
        .pdx           (b_pdx),
        .pdy           (b_pdy),
        .fdx           (b_fdx),
        .fdy           (b_fdy),
        .ctrl          (b_ctrl),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .inside_res    (inside_res),
        .quarter_turns (quarter_turns)
    );

    // result stays within the saturation bounds
    `PIPW_ASSERT_NOW(a_turns_range, out_valid,
        (quarter_turns <= AccLimit) && (quarter_turns >= -AccLimit),
        "quarter_turns outside saturation bounds")

    // inside flag agrees with the reported winding sum
    `PIPW_ASSERT_NOW(a_inside_match, out_valid,
        inside_res == ((quarter_turns >= Two) || (quarter_turns <= -Two)),
        "inside_res disagrees with quarter_turns")

    // a full queue never takes a vertex, so it stays stalled until the back end pops
    `PIPW_ASSERT_NEXT(a_queue_hold, q_full && !q_pop, in_stall,
        "queue full state lost without a pop")

endmodule
